FILE: rtl/ps2_mouse_packet_cursor_tracker_assert.svh
// assertion macros shared by the tracker's checker
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// clocked check, masked while reset is high
`define PS2MT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define PS2MT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ps2mt_pkg.sv
// shared types and constants of the ps2 mouse cursor tracker
package ps2mt_pkg;

  localparam int POSITION_BITS = 12;
  localparam int CFG_W = 13;
  localparam int CFG_INDEX_W = 4;
  localparam int DELTA_W = 10;
  localparam int SUM_W = ((POSITION_BITS > CFG_W) ? POSITION_BITS : CFG_W) + 2;

  localparam int OVF_EXTRA = 255;

  // header byte bit positions
  localparam int BTN_LEFT_BIT = 0;
  localparam int BTN_RIGHT_BIT = 1;
  localparam int BTN_MIDDLE_BIT = 2;
  localparam int SYNC_BIT = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;
  localparam int X_OVF_BIT = 6;
  localparam int Y_OVF_BIT = 7;

  localparam logic [CFG_W-1:0] RESET_WIDTH = CFG_W'(640);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH = 4'd0,
    REG_SCREEN_HEIGHT = 4'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BYTE_HEADER = 2'd0,
    BYTE_X = 2'd1,
    BYTE_Y = 2'd2
  } byte_slot_t;

  // one axis worth of movement taken from a packet
  typedef struct packed {
    logic [7:0] low;
    logic       neg;
    logic       ovf;
  } axis_move_t;

endpackage

FILE: rtl/ps2_mouse_packet_cursor_tracker.sv
// ps2 mouse 3-byte packet assembler and saturating cursor tracker
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | sink      | in_valid / in_ready  | data_byte
//  out     | source    | out_valid / out_ready| pos_x pos_y left/right/middle_button
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index cfg_data
//
// one byte per cycle, unless an unread result holds a third byte: a byte is held
// in the input register, then the sequencer and both axis adders/clamps update.
// out_valid comes from the result register, loaded as the third byte moves on.
// rst is synchronous: sequencer back to header, cursor to 0, sizes to 640x480.
// an unread result stalls only a third byte; header and x bytes keep flowing.
// cfg_ready is always high.
module ps2_mouse_packet_cursor_tracker
  import ps2mt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // byte stream
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               data_byte,
  // result stream
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POSITION_BITS-1:0] pos_x,
  output logic [POSITION_BITS-1:0] pos_y,
  output logic                     left_button,
  output logic                     right_button,
  output logic                     middle_button,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  // configuration
  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;

  // input register
  logic       byte_valid;
  logic [7:0] byte_q;

  // packet state
  byte_slot_t byte_index;
  byte_slot_t byte_index_next;
  logic [7:0] header_byte;
  logic [7:0] x_move_byte;
  logic [POSITION_BITS-1:0] cursor_x;
  logic [POSITION_BITS-1:0] cursor_y;
  logic [POSITION_BITS-1:0] cursor_x_next;
  logic [POSITION_BITS-1:0] cursor_y_next;

  logic       out_free;
  logic       completes;
  logic       byte_fire;
  axis_move_t move_x;
  axis_move_t move_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // a held byte moves on unless it ends a packet while the result is still waiting
  assign out_free = !out_valid || out_ready;
  assign completes = (byte_index == BYTE_Y);
  assign byte_fire = byte_valid && (!completes || out_free);
  assign in_ready = !byte_valid || byte_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= data_byte;
    end
  end

  // sequencer: header waits for the always-one sync bit, then x, then y
  always_comb begin
    byte_index_next = byte_index;
    if (byte_fire) begin
      case (byte_index)
        BYTE_X:  byte_index_next = BYTE_Y;
        BYTE_Y:  byte_index_next = BYTE_HEADER;
        default: byte_index_next = byte_q[SYNC_BIT] ? BYTE_X : BYTE_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= BYTE_HEADER;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  // packet bytes only ever read after being written, so no reset
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      if (byte_index == BYTE_X) begin
        x_move_byte <= byte_q;
      end else if (byte_index != BYTE_Y && byte_q[SYNC_BIT]) begin
        header_byte <= byte_q;
      end
    end
  end

  assign move_x = '{low: x_move_byte, neg: header_byte[X_SIGN_BIT],
                    ovf: header_byte[X_OVF_BIT]};
  assign move_y = '{low: byte_q, neg: header_byte[Y_SIGN_BIT],
                    ovf: header_byte[Y_OVF_BIT]};

  // x adds, y subtracts since rows grow downward
  ps2mt_cursor_axis u_axis_x (
    .cursor      (cursor_x),
    .move        (move_x),
    .invert      (1'b0),
    .size        (screen_width),
    .cursor_next (cursor_x_next)
  );

  ps2mt_cursor_axis u_axis_y (
    .cursor      (cursor_y),
    .move        (move_y),
    .invert      (1'b1),
    .size        (screen_height),
    .cursor_next (cursor_y_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (byte_fire && completes) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= byte_fire && completes;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire && completes) begin
      pos_x <= cursor_x_next;
      pos_y <= cursor_y_next;
      left_button <= header_byte[BTN_LEFT_BIT];
      right_button <= header_byte[BTN_RIGHT_BIT];
      middle_button <= header_byte[BTN_MIDDLE_BIT];
    end
  end

endmodule

FILE: rtl/ps2mt_cursor_axis.sv
// one cursor axis: signed delta decode, add or subtract, saturate to the frame
module ps2mt_cursor_axis
  import ps2mt_pkg::*;
(
  input  logic [POSITION_BITS-1:0] cursor,
  input  axis_move_t               move,
  input  logic                     invert,
  input  logic [CFG_W-1:0]         size,
  output logic [POSITION_BITS-1:0] cursor_next
);

  localparam logic [POSITION_BITS-1:0] POS_MASK = '1;

  logic signed [DELTA_W-1:0] delta;
  logic signed [DELTA_W-1:0] ovf_adj;
  logic signed [SUM_W-1:0]   delta_ext;
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]          top;

  always_comb begin
    // 9-bit two's complement move, overflow pushes 255 further
    ovf_adj = move.neg ? -DELTA_W'(OVF_EXTRA) : DELTA_W'(OVF_EXTRA);
    delta = $signed({{2{move.neg}}, move.low});
    if (move.ovf) begin
      delta = delta + ovf_adj;
    end
    delta_ext = SUM_W'(delta);
    if (invert) begin
      sum = $signed(SUM_W'(cursor)) - delta_ext;
    end else begin
      sum = $signed(SUM_W'(cursor)) + delta_ext;
    end

    // upper bound: size minus one, zero size acts as one, capped by position range
    if (size == '0) begin
      top = '0;
    end else begin
      top = SUM_W'(size) - SUM_W'(1);
    end
    if (top > SUM_W'(POS_MASK)) begin
      top = SUM_W'(POS_MASK);
    end

    if (sum < 0) begin
      cursor_next = '0;
    end else if ($unsigned(sum) > top) begin
      cursor_next = top[POSITION_BITS-1:0];
    end else begin
      cursor_next = sum[POSITION_BITS-1:0];
    end
  end

endmodule

FILE: rtl/ps2mt_checker.sv
// port-level checks for the ps2 mouse cursor tracker, bound to the top level
`include "ps2_mouse_packet_cursor_tracker_assert.svh"

module ps2mt_checker
  import ps2mt_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [POSITION_BITS-1:0] pos_x,
  input logic [POSITION_BITS-1:0] pos_y,
  input logic                     left_button,
  input logic                     right_button,
  input logic                     middle_button,
  input logic                     cfg_valid,
  input logic                     cfg_ready
);

  // a stalled result keeps its payload
  `PS2MT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y) && $stable({left_button, right_button, middle_button}), "result changed while stalled")

  // a fresh result follows a byte transaction, through the input and result registers
  `PS2MT_ASSERT(a_out_source, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a byte transaction")

  // nothing pending right after reset
  `PS2MT_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

  // register writes are never back-pressured
  `PS2MT_ASSERT(a_cfg_open, cfg_valid |-> cfg_ready, "register write stalled")

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mt_checker u_checker (.*);
